// ----- rtl/avmn_pkg.sv -----
// shared constants, types and helpers for the vector magnitude and normalise block
// no dependencies; every other file imports this package
package avmn_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int NORM_FRAC_BITS = 14;

   localparam int AXES       = 3;
   localparam int AXIS_W     = 16;
   localparam int SUM_W      = 2 * AXIS_W;
   localparam int ROOT_W     = AXIS_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int QUOT_W     = NORM_FRAC_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(QUOT_W);
   localparam int WIN_W      = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [AXIS_W-1:0] SAMPLE_MASK =
      AXIS_W'({AXIS_W{1'b1}} << (AXIS_W - SAMPLE_WIDTH));

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH = CSR_IDX_W'(1);

   localparam logic [WIN_W-1:0] WINDOW_LOW_RESET  = WIN_W'(12800);
   localparam logic [WIN_W-1:0] WINDOW_HIGH_RESET = WIN_W'(19200);

   localparam logic [31:0] POS_LIMIT = 32'd32767;
   localparam logic [31:0] NEG_LIMIT = 32'd32768;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_RUN,
      UNIT_DONE
   } avmn_unit_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } avmn_unit_ctrl_type;

   typedef struct packed {
      logic ready;
      logic done;
   } avmn_unit_status_type;

   // apply sign and clamp to the signed 16-bit output range
   function automatic logic signed [AXIS_W-1:0] avmn_saturate(
      input logic [QUOT_W-1:0] q,
      input logic              neg
   );
      logic [31:0] qx;
      logic [31:0] nx;
      qx = 32'(q);
      nx = 32'd0 - qx;
      if (neg) begin
         if (qx > NEG_LIMIT) begin
            return AXIS_W'(NEG_LIMIT);
         end
         return nx[AXIS_W-1:0];
      end
      if (qx > POS_LIMIT) begin
         return AXIS_W'(POS_LIMIT);
      end
      return qx[AXIS_W-1:0];
   endfunction

endpackage

// ----- rtl/accel_vector_magnitude_normalize.sv -----
// top level: input register, squaring lanes, square-root unit, three divide lanes,
// merging output register and window registers
// depends on avmn_pkg, avmn_sqrt, avmn_div_lane
//
// Input beats carry three signed axis counts on req_raw_x/y/z; a beat moves when
// req_valid is high and req_stall low. Each beat gives exactly one result beat on
// the rsp_ channel: magnitude, the three normalised axes, the in-window flag and
// the zero-vector flag, moved when rsp_valid is high and rsp_stall low.
// Window bounds are written on the csr_ channel (index 0 low, 1 high); csr_ready
// is always high and unknown indexes are dropped.
// Throughput is set by the square-root unit, which loads a radicand and then
// iterates over the root bits; the divide lanes load and then iterate over
// the quotient bits.
// Up to five samples are in flight: input register, squares, root, divide and
// the output register.
// Synchronous reset empties the pipeline and restores the default window.
// A stalled result is held in the output register while the stages behind it
// keep working until each holds a finished beat; req_stall then rises.
module accel_vector_magnitude_normalize (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [avmn_pkg::AXIS_W-1:0]  req_raw_x,
   input  logic signed [avmn_pkg::AXIS_W-1:0]  req_raw_y,
   input  logic signed [avmn_pkg::AXIS_W-1:0]  req_raw_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [avmn_pkg::ROOT_W-1:0]         rsp_magnitude,
   output logic signed [avmn_pkg::AXIS_W-1:0]  rsp_norm_x,
   output logic signed [avmn_pkg::AXIS_W-1:0]  rsp_norm_y,
   output logic signed [avmn_pkg::AXIS_W-1:0]  rsp_norm_z,
   output logic                                rsp_in_window,
   output logic                                rsp_zero_vector,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [avmn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [avmn_pkg::WIN_W-1:0]          csr_data
);
   import avmn_pkg::*;

   logic [WIN_W-1:0]         win_low_ff, win_high_ff;

   logic                     in_vld_ff, in_vld_in;
   logic signed [AXIS_W-1:0] in_ax_ff [AXES];
   logic signed [AXIS_W-1:0] req_ax [AXES];

   logic                     sq_vld_ff, sq_vld_in;
   logic [SUM_W-1:0]         sq_ff [AXES];
   logic signed [AXIS_W-1:0] sq_ax_ff [AXES];
   logic signed [SUM_W-1:0]  prod [AXES];
   logic [SUM_W-1:0]         sum_sq;

   logic signed [AXIS_W-1:0] sr_ax_ff [AXES];
   avmn_unit_ctrl_type       sqrt_ctrl;
   avmn_unit_status_type     sqrt_status;
   logic [ROOT_W-1:0]        sqrt_root;

   avmn_unit_ctrl_type       div_ctrl;
   avmn_unit_status_type     div_status [AXES];
   logic [QUOT_W-1:0]        div_quot [AXES];
   logic [AXIS_W-1:0]        div_abs [AXES];
   logic [AXES-1:0]          div_ready, div_done;
   logic [AXES-1:0]          dv_neg_ff;
   logic                     dv_zero_ff;
   logic [ROOT_W-1:0]        dv_mag_ff;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic [ROOT_W-1:0]        rsp_mag_ff;
   logic signed [AXIS_W-1:0] rsp_norm_ff [AXES];
   logic                     rsp_win_ff;
   logic                     rsp_zero_ff;

   logic                     out_free, sq_free, in_go, req_acc;
   logic                     sqrt_start, div_start, div_take;

   // window registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff  <= WINDOW_LOW_RESET;
         win_high_ff <= WINDOW_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LOW: begin
               win_low_ff <= csr_data;
            end
            CSR_WINDOW_HIGH: begin
               win_high_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   assign req_ax[0] = req_raw_x & SAMPLE_MASK;
   assign req_ax[1] = req_raw_y & SAMPLE_MASK;
   assign req_ax[2] = req_raw_z & SAMPLE_MASK;

   always_comb begin
      out_free   = !rsp_vld_ff || !rsp_stall;
      div_take   = (&div_done) && out_free;
      div_start  = sqrt_status.done && (&div_ready);
      sqrt_start = sq_vld_ff && sqrt_status.ready;
      sq_free    = !sq_vld_ff || sqrt_start;
      in_go      = in_vld_ff && sq_free;
      req_stall  = in_vld_ff && !sq_free;
      req_acc    = req_valid && !req_stall;

      in_vld_in  = req_acc || (in_vld_ff && !in_go);
      sq_vld_in  = in_go || (sq_vld_ff && !sqrt_start);
      rsp_vld_in = out_free ? div_take : rsp_vld_ff;

      sqrt_ctrl.start = sqrt_start;
      sqrt_ctrl.take  = div_start;
      div_ctrl.start  = div_start;
      div_ctrl.take   = div_take;

      sum_sq = SUM_W'(sq_ff[0] + sq_ff[1] + sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         sq_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         sq_vld_ff  <= sq_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // squaring lanes and per-lane payload carried alongside the shared root
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      assign prod[i]    = in_ax_ff[i] * in_ax_ff[i];
      assign div_abs[i] = sr_ax_ff[i][AXIS_W-1] ? AXIS_W'(-sr_ax_ff[i]) : sr_ax_ff[i];

      always_ff @(posedge clock) begin
         if (req_acc) begin
            in_ax_ff[i] <= req_ax[i];
         end
         if (in_go) begin
            sq_ff[i]    <= prod[i];
            sq_ax_ff[i] <= in_ax_ff[i];
         end
         if (sqrt_start) begin
            sr_ax_ff[i] <= sq_ax_ff[i];
         end
         if (div_start) begin
            dv_neg_ff[i] <= sr_ax_ff[i][AXIS_W-1];
         end
         if (div_take) begin
            rsp_norm_ff[i] <= dv_zero_ff ? '0 : avmn_saturate(div_quot[i], dv_neg_ff[i]);
         end
      end

      avmn_div_lane u_div (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (div_ctrl),
         .divisor  (sqrt_root),
         .dividend (div_abs[i]),
         .status   (div_status[i]),
         .quotient (div_quot[i])
      );

      assign div_ready[i] = div_status[i].ready;
      assign div_done[i]  = div_status[i].done;
   end

   avmn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sqrt_ctrl),
      .radicand (sum_sq),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   // merging stage
   always_ff @(posedge clock) begin
      if (div_start) begin
         dv_mag_ff  <= sqrt_root;
         dv_zero_ff <= (sqrt_root == '0);
      end
      if (div_take) begin
         rsp_mag_ff  <= dv_mag_ff;
         rsp_zero_ff <= dv_zero_ff;
         rsp_win_ff  <= (dv_mag_ff > win_low_ff) && (dv_mag_ff < win_high_ff);
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_magnitude   = rsp_mag_ff;
   assign rsp_norm_x      = rsp_norm_ff[0];
   assign rsp_norm_y      = rsp_norm_ff[1];
   assign rsp_norm_z      = rsp_norm_ff[2];
   assign rsp_in_window   = rsp_win_ff;
   assign rsp_zero_vector = rsp_zero_ff;

`ifndef ASSERT_OFF
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (div_done == '0) || (div_done == '1))
      else $error("divide lanes out of step");

   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_zero_ff) |-> (rsp_mag_ff == '0) && (rsp_norm_ff[0] == '0)
         && (rsp_norm_ff[1] == '0) && (rsp_norm_ff[2] == '0))
      else $error("zero vector beat with non-zero fields");

   a_window_not_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_win_ff) |-> !rsp_zero_ff)
      else $error("in-window flag on a zero vector");

   a_root_held: assert property (@(posedge clock) disable iff (reset)
      (sqrt_status.done && !div_start) |=> (sqrt_status.done && $stable(sqrt_root)))
      else $error("finished root lost before divide lanes took it");
`endif

endmodule

// ----- rtl/avmn_sqrt.sv -----
// iterative integer square root, one result bit per cycle
// depends on avmn_pkg
module avmn_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  avmn_pkg::avmn_unit_ctrl_type        ctrl,
   input  logic [avmn_pkg::SUM_W-1:0]          radicand,
   output avmn_pkg::avmn_unit_status_type      status,
   output logic [avmn_pkg::ROOT_W-1:0]         root
);
   import avmn_pkg::*;

   avmn_unit_state_type   state_ff, state_in;
   logic [SUM_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;
   logic [REM_W+1:0]      diff;
   logic                  last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   always_comb begin
      rem_sh = {rem_ff, rad_ff[SUM_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      diff   = rem_sh - trial;
      last   = (cnt_ff == SQRT_CNT_W'(ROOT_W - 1));

      status.ready = (state_ff == UNIT_IDLE) || ((state_ff == UNIT_DONE) && ctrl.take);
      status.done  = (state_ff == UNIT_DONE);

      state_in = state_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;

      case (state_ff)
         UNIT_IDLE: begin
            state_in = UNIT_IDLE;
         end
         UNIT_RUN: begin
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + SQRT_CNT_W'(1);
            if (rem_sh >= trial) begin
               rem_in  = diff[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (last) begin
               state_in = UNIT_DONE;
            end
         end
         UNIT_DONE: begin
            if (ctrl.take) begin
               state_in = UNIT_IDLE;
            end
         end
         default: begin
            state_in = UNIT_IDLE;
         end
      endcase

      if (ctrl.start && status.ready) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         cnt_in   = '0;
         state_in = UNIT_RUN;
      end
   end

   assign root = root_ff;

endmodule

// ----- rtl/avmn_div_lane.sv -----
// one normalise lane: restoring divide of a scaled axis magnitude by the vector length
// depends on avmn_pkg
module avmn_div_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  avmn_pkg::avmn_unit_ctrl_type        ctrl,
   input  logic [avmn_pkg::ROOT_W-1:0]         divisor,
   input  logic [avmn_pkg::AXIS_W-1:0]         dividend,
   output avmn_pkg::avmn_unit_status_type      status,
   output logic [avmn_pkg::QUOT_W-1:0]         quotient
);
   import avmn_pkg::*;

   avmn_unit_state_type  state_ff, state_in;
   logic [ROOT_W-1:0]    rem_ff, rem_in;
   logic [QUOT_W-1:0]    dq_ff, dq_in;
   logic [ROOT_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROOT_W:0]      trial;
   logic [ROOT_W:0]      dvs_x;
   logic [ROOT_W:0]      diff;
   logic                 ge;
   logic                 last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      trial = {rem_ff, dq_ff[QUOT_W-1]};
      dvs_x = {1'b0, dvs_ff};
      diff  = trial - dvs_x;
      ge    = (trial >= dvs_x);
      last  = (cnt_ff == DIV_CNT_W'(QUOT_W - 1));

      status.ready = (state_ff == UNIT_IDLE) || ((state_ff == UNIT_DONE) && ctrl.take);
      status.done  = (state_ff == UNIT_DONE);

      state_in = state_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;

      case (state_ff)
         UNIT_IDLE: begin
            state_in = UNIT_IDLE;
         end
         UNIT_RUN: begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            rem_in = ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
            dq_in  = {dq_ff[QUOT_W-2:0], ge};
            if (last) begin
               state_in = UNIT_DONE;
            end
         end
         UNIT_DONE: begin
            if (ctrl.take) begin
               state_in = UNIT_IDLE;
            end
         end
         default: begin
            state_in = UNIT_IDLE;
         end
      endcase

      // dividend scaled by the fraction bits; top bits seed the remainder
      if (ctrl.start && status.ready) begin
         rem_in   = ROOT_W'(dividend >> 1);
         dq_in    = {dividend[0], {NORM_FRAC_BITS{1'b0}}};
         dvs_in   = divisor;
         cnt_in   = '0;
         state_in = UNIT_RUN;
      end
   end

   assign quotient = dq_ff;

endmodule

// ----- tb/testbench.sv -----
// testbench for accel_vector_magnitude_normalize: directed and random samples checked
// beat by beat against an in-bench predictor of magnitude, normalised axes and flags
// depends on avmn_pkg and the block's top-level module
module testbench;
   import avmn_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = CSR_IDX_W'(3);
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_PER_PHASE = 630;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        magnitude;
      logic signed [AXIS_W-1:0] norm_x;
      logic signed [AXIS_W-1:0] norm_y;
      logic signed [AXIS_W-1:0] norm_z;
      logic                     in_window;
      logic                     zero_vector;
   } unit_vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [AXIS_W-1:0] req_raw_x = '0;
   logic signed [AXIS_W-1:0] req_raw_y = '0;
   logic signed [AXIS_W-1:0] req_raw_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ROOT_W-1:0] rsp_magnitude;
   logic signed [AXIS_W-1:0] rsp_norm_x;
   logic signed [AXIS_W-1:0] rsp_norm_y;
   logic signed [AXIS_W-1:0] rsp_norm_z;
   logic rsp_in_window;
   logic rsp_zero_vector;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WIN_W-1:0] csr_data = '0;

   logic [WIN_W-1:0] bound_low = WINDOW_LOW_RESET;
   logic [WIN_W-1:0] bound_high = WINDOW_HIGH_RESET;

   unit_vector_type expected_unit_vectors[$];
   int fault_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   accel_vector_magnitude_normalize DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_raw_x(req_raw_x),
      .req_raw_y(req_raw_y),
      .req_raw_z(req_raw_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_magnitude(rsp_magnitude),
      .rsp_norm_x(rsp_norm_x),
      .rsp_norm_y(rsp_norm_y),
      .rsp_norm_z(rsp_norm_z),
      .rsp_in_window(rsp_in_window),
      .rsp_zero_vector(rsp_zero_vector),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint int_sqrt(input longint n);
      longint root;
      longint trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [AXIS_W-1:0] scale_axis(input longint a, input longint mag);
      longint q;
      q = ((a < 0 ? -a : a) << NORM_FRAC_BITS) / mag;
      if (a < 0) begin
         q = -q;
      end
      if (q > 32767) begin
         q = 32767;
      end
      if (q < -32768) begin
         q = -32768;
      end
      return AXIS_W'(q);
   endfunction

   function automatic unit_vector_type predict_unit_vector(input sample_type s);
      logic signed [AXIS_W-1:0] mx;
      logic signed [AXIS_W-1:0] my;
      logic signed [AXIS_W-1:0] mz;
      longint lx;
      longint ly;
      longint lz;
      longint mag;
      unit_vector_type r;
      mx = s.x & SAMPLE_MASK;
      my = s.y & SAMPLE_MASK;
      mz = s.z & SAMPLE_MASK;
      lx = longint'(mx);
      ly = longint'(my);
      lz = longint'(mz);
      mag = int_sqrt(lx * lx + ly * ly + lz * lz);
      r.magnitude = ROOT_W'(mag);
      if (mag == 0) begin
         r.norm_x = '0;
         r.norm_y = '0;
         r.norm_z = '0;
      end else begin
         r.norm_x = scale_axis(lx, mag);
         r.norm_y = scale_axis(ly, mag);
         r.norm_z = scale_axis(lz, mag);
      end
      r.in_window = (mag > longint'(bound_low)) && (mag < longint'(bound_high));
      r.zero_vector = (mag == 0);
      return r;
   endfunction

   // receiver stall, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      unit_vector_type want;
      unit_vector_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_magnitude, rsp_norm_x, rsp_norm_y, rsp_norm_z,
                 rsp_in_window, rsp_zero_vector};
         if (expected_unit_vectors.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("unexpected result beat: mag %0d norm %0d %0d %0d win %0b zero %0b",
                        got.magnitude, got.norm_x, got.norm_y, got.norm_z,
                        got.in_window, got.zero_vector);
            end
         end else begin
            want = expected_unit_vectors.pop_front();
            if (got.magnitude !== want.magnitude || got.norm_x !== want.norm_x ||
                got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
                got.in_window !== want.in_window || got.zero_vector !== want.zero_vector) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected mag %0d norm %0d %0d %0d win %0b zero %0b",
                           want.magnitude, want.norm_x, want.norm_y, want.norm_z,
                           want.in_window, want.zero_vector);
                  $display("          actual   mag %0d norm %0d %0d %0d win %0b zero %0b",
                           got.magnitude, got.norm_x, got.norm_y, got.norm_z,
                           got.in_window, got.zero_vector);
               end
            end
         end
      end
   end

   // called at a falling edge; leaves req_valid high on return
   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_x <= s.x;
      req_raw_y <= s.y;
      req_raw_z <= s.z;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_unit_vectors.push_back(predict_unit_vector(s));
      @(negedge clock);
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      while (expected_unit_vectors.size() != 0) begin
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (idx == CSR_WINDOW_LOW) begin
         bound_low = value;
      end else if (idx == CSR_WINDOW_HIGH) begin
         bound_high = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_window(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
      await_drain();
      write_register(CSR_WINDOW_LOW, lo);
      write_register(CSR_WINDOW_HIGH, hi);
   endtask

   function automatic sample_type near_window_sample();
      longint m;
      longint lim;
      longint rx;
      longint ry;
      longint rz;
      sample_type s;
      case ($urandom_range(2))
         0: m = longint'(bound_low) + longint'($urandom_range(4)) - 2;
         1: m = longint'(bound_high) + longint'($urandom_range(4)) - 2;
         default: m = longint'($urandom_range(24000, 8000));
      endcase
      if (m < 0) begin
         m = 0;
      end
      if (m > 56755) begin
         m = 56755;
      end
      lim = (m > 32767) ? 32767 : m;
      rx = longint'($urandom_range(2 * lim)) - lim;
      lim = int_sqrt(m * m - rx * rx);
      if (lim > 32767) begin
         lim = 32767;
      end
      ry = longint'($urandom_range(2 * lim)) - lim;
      rz = int_sqrt(m * m - rx * rx - ry * ry);
      if (rz > 32767) begin
         rz = 32767;
      end
      if ($urandom_range(1)) begin
         rz = -rz;
      end
      s.x = AXIS_W'(rx);
      s.y = AXIS_W'(ry);
      s.z = AXIS_W'(rz);
      return s;
   endfunction

   function automatic logic signed [AXIS_W-1:0] edge_axis();
      case ($urandom_range(4))
         0: return -16'sd32768;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         s.x = AXIS_W'($urandom);
         s.y = AXIS_W'($urandom);
         s.z = AXIS_W'($urandom);
      end else if (pick < 72) begin
         s = near_window_sample();
      end else if (pick < 87) begin
         s.x = AXIS_W'(longint'($urandom_range(8)) - 4);
         s.y = AXIS_W'(longint'($urandom_range(8)) - 4);
         s.z = AXIS_W'(longint'($urandom_range(8)) - 4);
      end else if (pick < 97) begin
         s.x = edge_axis();
         s.y = edge_axis();
         s.z = edge_axis();
      end else begin
         s = '0;
      end
      return s;
   endfunction

   task automatic test_extreme_samples();
      send_sample('{16'sd0, 16'sd0, 16'sd0});
      send_sample('{-16'sd32768, 16'sd0, 16'sd0});
      send_sample('{16'sd32767, 16'sd0, 16'sd0});
      send_sample('{16'sd0, -16'sd32768, 16'sd0});
      send_sample('{16'sd0, 16'sd0, 16'sd32767});
      send_sample('{-16'sd32768, -16'sd32768, -16'sd32768});
      send_sample('{16'sd32767, 16'sd32767, 16'sd32767});
      send_sample('{16'sd1, 16'sd1, 16'sd1});
      send_sample('{-16'sd1, -16'sd1, -16'sd1});
      send_sample('{16'sd3, -16'sd4, 16'sd0});
   endtask

   task automatic test_default_window_edges();
      send_sample('{16'sd12800, 16'sd0, 16'sd0});
      send_sample('{16'sd0, -16'sd12801, 16'sd0});
      send_sample('{16'sd0, 16'sd0, 16'sd19199});
      send_sample('{-16'sd19200, 16'sd0, 16'sd0});
   endtask

   task automatic test_window_registers();
      set_window(16'd0, 16'd65535);
      send_sample('{16'sd1, 16'sd0, 16'sd0});
      send_sample('{-16'sd32768, -16'sd32768, -16'sd32768});
      set_window(16'd65535, 16'd0);
      send_sample('{16'sd16000, 16'sd0, 16'sd0});
      // empty window: no magnitude strictly between neighbours
      set_window(16'd100, 16'd101);
      send_sample('{16'sd100, 16'sd0, 16'sd0});
      send_sample('{16'sd101, 16'sd0, 16'sd0});
      set_window(16'd100, 16'd102);
      send_sample('{16'sd0, 16'sd101, 16'sd0});
      // writes to unmapped indexes leave the window untouched
      await_drain();
      write_register(CSR_UNMAPPED_A, 16'hFFFF);
      write_register(CSR_UNMAPPED_B, 16'h0000);
      send_sample('{16'sd0, 16'sd0, -16'sd101});
      set_window(WINDOW_LOW_RESET, WINDOW_HIGH_RESET);
   endtask

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 75) begin
            await_drain();
         end
         send_sample(random_sample());
      end
   endtask

   task automatic test_random_traffic();
      logic [WIN_W-1:0] lo;
      run_random_phase(RANDOM_PER_PHASE, 32, 76);
      lo = WIN_W'($urandom_range(16000, 8000));
      set_window(lo, lo + WIN_W'($urandom_range(12000)));
      run_random_phase(RANDOM_PER_PHASE, 76, 32);
      set_window(WIN_W'($urandom_range(30000)), WIN_W'($urandom));
      run_random_phase(RANDOM_PER_PHASE, 0, 0);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extreme_samples();
      test_default_window_edges();
      test_window_registers();
      test_random_traffic();
      await_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_unit_vectors.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/avmn_pkg.sv
rtl/avmn_sqrt.sv
rtl/avmn_div_lane.sv
rtl/accel_vector_magnitude_normalize.sv
tb/testbench.sv
